// ----- hdl/ccrc_pkg.sv -----
// Shared types and constants for the changed-cell run coalescer.
// Holds the cell and run word layouts and the configuration register map.
// No dependencies.
`timescale 1ns / 1ps

package ccrc_pkg;

	localparam int CoordW   = 12;
	localparam int EndW     = 13;
	localparam int ColorW   = 8;
	localparam int GlyphW   = 21;
	localparam int PixW     = 18;
	localparam int SizeW    = 7;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 13;

	// Register reset values
	localparam logic [EndW-1:0]  VIEW_END_RST   = EndW'(4096);
	localparam logic [SizeW-1:0] GLYPH_W_RST    = SizeW'(8);
	localparam logic [SizeW-1:0] GLYPH_H_RST    = SizeW'(16);

	// Configuration register map
	typedef enum logic [CfgIdxW-1:0] {
		CFG_VIEW_ENABLE    = 3'd0,
		CFG_VIEW_START_COL = 3'd1,
		CFG_VIEW_START_ROW = 3'd2,
		CFG_VIEW_END_COL   = 3'd3,
		CFG_VIEW_END_ROW   = 3'd4,
		CFG_OLD_COMPARE    = 3'd5,
		CFG_GLYPH_WIDTH    = 3'd6,
		CFG_GLYPH_HEIGHT   = 3'd7
	} cfg_reg_t;

	// One input cell
	typedef struct packed {
		logic [CoordW-1:0] column;
		logic [CoordW-1:0] row;
		logic [ColorW-1:0] new_color;
		logic [GlyphW-1:0] new_glyph;
		logic [ColorW-1:0] old_color;
		logic [GlyphW-1:0] old_glyph;
		logic              span_end;
	} cell_t;

	// One emitted glyph of a run
	typedef struct packed {
		logic [ColorW-1:0] run_color;
		logic [PixW-1:0]   pixel_x;
		logic [PixW-1:0]   pixel_y;
		logic [GlyphW-1:0] glyph;
		logic              run_last;
	} run_word_t;

endpackage

// ----- hdl/ccrc_out_buf.sv -----
// Two-entry output buffer for emitted run words.
// Decouples the drain read pipeline from output back-pressure; uses ccrc_pkg.
`timescale 1ns / 1ps

module ccrc_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ccrc_pkg::run_word_t push_word,
	output logic [1:0]          level,
	output logic                run_valid,
	input  logic                run_ready,
	output ccrc_pkg::run_word_t run
);
	import ccrc_pkg::*;

	run_word_t  slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       pop;

	assign run_valid = (cnt_q != 2'd0);
	assign run       = slot_q[rd_ptr_q];
	assign level     = cnt_q;
	assign pop       = run_valid && run_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Word storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_word;
	end

endmodule

// ----- hdl/changed_cell_run_coalescer_core.sv -----
// Changed-cell run coalescer: top level.
// Uses ccrc_pkg and ccrc_out_buf; the run glyph memory lives here.
`timescale 1ns / 1ps

// Cells are taken one per cycle unless input is held off, as below.
// Visible, changed cells of one color are gathered into a run held in one
// bank of a two-bank glyph memory; when a run closes, its bank is handed to
// the drain side, which reads one glyph a cycle (registered memory read)
// into a two-word output buffer while that buffer has room, and the next
// run fills the other bank. A cell that closes a run is held off while the
// previous run is still being read out; a cell that both closes a run and
// ends the span with a fresh run takes one more handover, blocking input
// until the drain side frees. No clearing pass after reset. Output words
// carry color, pixel origin, glyph and a last-glyph marker.
module changed_cell_run_coalescer_core #(
	parameter int RUN_MAX = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [2:0]               cfg_index,
	input  logic [12:0]              cfg_data,
	input  logic                     cell_valid,
	output logic                     cell_ready,
	input  ccrc_pkg::cell_t          cell_word,
	output logic                     run_valid,
	input  logic                     run_ready,
	output ccrc_pkg::run_word_t      run
);
	import ccrc_pkg::*;

	localparam int CntW = $clog2(RUN_MAX + 1);
	localparam int IdxW = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
	localparam logic [CntW-1:0] RunMaxC = CntW'(RUN_MAX);

	typedef struct packed {
		logic [CntW-1:0]   count;
		logic [ColorW-1:0] color;
		logic [PixW-1:0]   px;
		logic [PixW-1:0]   py;
		logic              bank;
	} run_desc_t;

	// Configuration registers
	logic              view_en_q;
	logic [CoordW-1:0] start_col_q;
	logic [CoordW-1:0] start_row_q;
	logic [EndW-1:0]   end_col_q;
	logic [EndW-1:0]   end_row_q;
	logic              cmp_en_q;
	logic [SizeW-1:0]  gw_q;
	logic [SizeW-1:0]  gh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_en_q   <= 1'b0;
			start_col_q <= '0;
			start_row_q <= '0;
			end_col_q   <= VIEW_END_RST;
			end_row_q   <= VIEW_END_RST;
			cmp_en_q    <= 1'b0;
			gw_q        <= GLYPH_W_RST;
			gh_q        <= GLYPH_H_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_VIEW_ENABLE:    view_en_q   <= cfg_data[0];
				CFG_VIEW_START_COL: start_col_q <= cfg_data[CoordW-1:0];
				CFG_VIEW_START_ROW: start_row_q <= cfg_data[CoordW-1:0];
				CFG_VIEW_END_COL:   end_col_q   <= cfg_data[EndW-1:0];
				CFG_VIEW_END_ROW:   end_row_q   <= cfg_data[EndW-1:0];
				CFG_OLD_COMPARE:    cmp_en_q    <= cfg_data[0];
				CFG_GLYPH_WIDTH:    gw_q        <= cfg_data[SizeW-1:0];
				CFG_GLYPH_HEIGHT:   gh_q        <= cfg_data[SizeW-1:0];
				default:            ;
			endcase
		end
	end

	// Fill side state
	run_desc_t fill_q;
	logic      pend_q;

	// Drain side state
	run_desc_t       drain_q;
	logic            d_busy_q;
	logic [CntW-1:0] d_idx_q;

	// Glyph memory: two banks of one run each
	logic [GlyphW-1:0] mem_q [2][RUN_MAX];

	// Cell classification
	logic              visible;
	logic              changed;
	logic              flush_pre;
	logic              append;
	logic              flush_end;
	logic [CntW-1:0]   cnt_a;
	logic              bank_a;
	logic [CntW-1:0]   cnt_b;
	logic              first;
	logic [PixW-1:0]   dx;
	logic [PixW-1:0]   dy;
	logic [PixW-1:0]   px_new;
	logic [PixW-1:0]   py_new;
	logic              acc;
	logic              hand_pend;
	logic              wr_en;
	run_desc_t         after;
	run_desc_t         after_done;
	run_desc_t         held_done;

	// Drain read scheduling
	logic [1:0]        buf_level;
	logic              valid_s1;
	logic              issue;
	logic              d_last;
	logic [CntW-1:0]   d_next;
	logic [2:0]        occ;
	logic              pop;

	always_comb begin
		visible = !view_en_q ||
			(cell_word.column >= start_col_q && {1'b0, cell_word.column} < end_col_q &&
			 cell_word.row >= start_row_q && {1'b0, cell_word.row} < end_row_q);
		changed = !cmp_en_q || cell_word.new_color != cell_word.old_color ||
			cell_word.new_glyph != cell_word.old_glyph;
		flush_pre = (fill_q.count != '0) &&
			(!visible || !changed || cell_word.new_color != fill_q.color ||
			 fill_q.count >= RunMaxC);
		append = visible && changed;
		cnt_a  = flush_pre ? '0 : fill_q.count;
		bank_a = fill_q.bank ^ flush_pre;
		wr_en  = append && (cnt_a < RunMaxC);
		cnt_b  = wr_en ? CntW'(cnt_a + CntW'(1)) : cnt_a;
		first  = append && (cnt_a == '0);
		flush_end = cell_word.span_end && (cnt_b != '0);

		// Pixel origin of a new run
		dx     = PixW'(cell_word.column) - PixW'(start_col_q);
		dy     = PixW'(cell_word.row) - PixW'(start_row_q);
		px_new = dx * PixW'(gw_q);
		py_new = dy * PixW'(gh_q);

		after.count = cnt_b;
		after.color = first ? cell_word.new_color : fill_q.color;
		after.px    = first ? px_new : fill_q.px;
		after.py    = first ? py_new : fill_q.py;
		after.bank  = bank_a;

		// Fill state once its run is handed over: empty, other bank
		after_done       = after;
		after_done.count = '0;
		after_done.bank  = ~after.bank;
		held_done        = fill_q;
		held_done.count  = '0;
		held_done.bank   = ~fill_q.bank;
	end

	assign cell_ready = !pend_q && (!(flush_pre || flush_end) || !d_busy_q);
	assign acc        = cell_valid && cell_ready;
	assign hand_pend  = pend_q && !d_busy_q;

	// Fill state update and handover to drain side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			pend_q   <= 1'b0;
			drain_q  <= '0;
			d_busy_q <= 1'b0;
			d_idx_q  <= '0;
		end else begin
			if (acc) begin
				pend_q <= flush_pre && flush_end;
				if (flush_pre) begin
					fill_q   <= after;
					drain_q  <= fill_q;
					d_busy_q <= 1'b1;
					d_idx_q  <= '0;
				end else if (flush_end) begin
					fill_q   <= after_done;
					drain_q  <= after;
					d_busy_q <= 1'b1;
					d_idx_q  <= '0;
				end else begin
					fill_q <= after;
				end
			end else if (hand_pend) begin
				fill_q   <= held_done;
				drain_q  <= fill_q;
				d_busy_q <= 1'b1;
				d_idx_q  <= '0;
				pend_q   <= 1'b0;
			end

			if (issue) begin
				d_idx_q <= d_next;
				if (d_last) d_busy_q <= 1'b0;
			end
		end
	end

	// Drain read scheduling against output buffer space
	assign pop    = run_valid && run_ready;
	assign occ    = {1'b0, buf_level} + {2'b00, valid_s1};
	assign issue  = d_busy_q && (occ <= (3'd1 + {2'b00, pop}));
	assign d_next = CntW'(d_idx_q + CntW'(1));
	assign d_last = (d_next == drain_q.count);

	// Memory write and read ports
	logic [GlyphW-1:0] glyph_s1;
	logic [ColorW-1:0] color_s1;
	logic [PixW-1:0]   px_s1;
	logic [PixW-1:0]   py_s1;
	logic              last_s1;

	always_ff @(posedge clk) begin
		if (acc && wr_en) mem_q[bank_a][cnt_a[IdxW-1:0]] <= cell_word.new_glyph;
		if (issue) begin
			glyph_s1 <= mem_q[drain_q.bank][d_idx_q[IdxW-1:0]];
			color_s1 <= drain_q.color;
			px_s1    <= drain_q.px;
			py_s1    <= drain_q.py;
			last_s1  <= d_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	// Output buffer
	run_word_t push_word;

	always_comb begin
		push_word.run_color = color_s1;
		push_word.pixel_x   = px_s1;
		push_word.pixel_y   = py_s1;
		push_word.glyph     = glyph_s1;
		push_word.run_last  = last_s1;
	end

	ccrc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_word (push_word),
		.level     (buf_level),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run)
	);

endmodule

// ----- tb/sv/ccrc_run_checker.sv -----
// Checker for the changed-cell run coalescer: watches both channels and config writes.
// Predicts run words per accepted cell and compares them in order.
// Depends on ccrc_pkg.
`timescale 1ns / 1ps

module ccrc_run_checker #(
	parameter int RUN_MAX = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [12:0]         cfg_data,
	input  logic                cell_valid,
	input  logic                cell_ready,
	input  ccrc_pkg::cell_t     cell_word,
	input  logic                run_valid,
	input  logic                run_ready,
	input  ccrc_pkg::run_word_t run_word,
	input  logic                wrap_up,
	output int                  mismatches,
	output int                  words_pending
);
	import ccrc_pkg::*;

	// Register copies
	logic              view_on;
	logic [11:0]       start_col, start_row;
	logic [12:0]       end_col, end_row;
	logic              cmp_old;
	logic [6:0]        cell_w, cell_h;

	// Open run
	logic [20:0]       glyph_store [RUN_MAX];
	int                glyph_count;
	logic [7:0]        open_color;
	logic [17:0]       open_x, open_y;

	run_word_t         expected_words [$];
	run_word_t         due_word;
	bit                wrapped;

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s expected %0h actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Close the open run: one word per glyph, last marker on the final one
	task automatic flush_open_run();
		run_word_t w;
		for (int i = 0; i < glyph_count; i++) begin
			w.run_color = open_color;
			w.pixel_x   = open_x;
			w.pixel_y   = open_y;
			w.glyph     = glyph_store[i];
			w.run_last  = (i == glyph_count - 1);
			expected_words.push_back(w);
		end
		glyph_count = 0;
	endtask

	task automatic predict_cell(input cell_t c);
		logic        visible;
		logic        changed;
		logic [17:0] dx, dy;
		visible = 1'b1;
		if (view_on)
			visible = c.column >= start_col && 13'(c.column) < end_col &&
				c.row >= start_row && 13'(c.row) < end_row;
		changed = !cmp_old || c.new_color != c.old_color || c.new_glyph != c.old_glyph;

		// Break the open run first
		if (glyph_count != 0 && (!visible || !changed || c.new_color != open_color ||
				glyph_count >= RUN_MAX))
			flush_open_run();

		// Append; a fresh run takes color and origin from this cell
		if (visible && changed) begin
			if (glyph_count == 0) begin
				dx         = 18'(c.column) - 18'(start_col);
				dy         = 18'(c.row) - 18'(start_row);
				open_color = c.new_color;
				open_x     = dx * 18'(cell_w);
				open_y     = dy * 18'(cell_h);
			end
			if (glyph_count < RUN_MAX) begin
				glyph_store[glyph_count] = c.new_glyph;
				glyph_count++;
			end
		end

		if (c.span_end && glyph_count != 0)
			flush_open_run();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_on     <= 1'b0;
			start_col   <= '0;
			start_row   <= '0;
			end_col     <= VIEW_END_RST;
			end_row     <= VIEW_END_RST;
			cmp_old     <= 1'b0;
			cell_w      <= GLYPH_W_RST;
			cell_h      <= GLYPH_H_RST;
			glyph_count = 0;
			open_color  = '0;
			open_x      = '0;
			open_y      = '0;
			wrapped     = 1'b0;
			expected_words.delete();
			words_pending = 0;
		end else begin
			// Output side: compare against the oldest expectation
			if (run_valid && run_ready) begin
				if (expected_words.size() == 0) begin
					$error("run word with nothing expected: glyph %0h", run_word.glyph);
					mismatches++;
				end else begin
					due_word = expected_words.pop_front();
					check_field("run_color", due_word.run_color, run_word.run_color);
					check_field("pixel_x", due_word.pixel_x, run_word.pixel_x);
					check_field("pixel_y", due_word.pixel_y, run_word.pixel_y);
					check_field("glyph", due_word.glyph, run_word.glyph);
					check_field("run_last", due_word.run_last, run_word.run_last);
				end
			end

			// Config writes
			if (cfg_write) begin
				case (cfg_index)
					CFG_VIEW_ENABLE:    view_on   <= cfg_data[0];
					CFG_VIEW_START_COL: start_col <= cfg_data[11:0];
					CFG_VIEW_START_ROW: start_row <= cfg_data[11:0];
					CFG_VIEW_END_COL:   end_col   <= cfg_data;
					CFG_VIEW_END_ROW:   end_row   <= cfg_data;
					CFG_OLD_COMPARE:    cmp_old   <= cfg_data[0];
					CFG_GLYPH_WIDTH:    cell_w    <= cfg_data[6:0];
					CFG_GLYPH_HEIGHT:   cell_h    <= cfg_data[6:0];
					default: ;
				endcase
			end

			// Input side
			if (cell_valid && cell_ready)
				predict_cell(cell_word);

			// Anything still expected at wrap-up never arrived
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (expected_words.size() != 0) begin
					$error("%0d run words expected but never seen", expected_words.size());
					mismatches += expected_words.size();
				end
			end

			words_pending = expected_words.size();
		end
	end

endmodule

// ----- tb/sv/tb_changed_cell_run_coalescer_core.sv -----
// Testbench top for changed_cell_run_coalescer_core: clock, reset, cell stimulus,
// run-side back-pressure and the verdict. Checking lives in ccrc_run_checker.
// Depends on ccrc_pkg, ccrc_run_checker and the core.
`timescale 1ns / 1ps

module tb_changed_cell_run_coalescer_core;
	import ccrc_pkg::*;

	localparam int RUN_MAX       = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int GLYPH_TOP     = 1114111;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_write  = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [12:0] cfg_data   = '0;
	logic        cell_valid = 1'b0;
	logic        cell_ready;
	cell_t       cell_word  = '0;
	logic        run_valid;
	logic        run_ready  = 1'b0;
	run_word_t   run_word;
	logic        wrap_up    = 1'b0;
	int          mismatches;
	int          words_pending;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;
	int cycle_count    = 0;
	int items_sent     = 0;

	// Coordinate ranges that cell generation aims at
	int win_col_lo = 0, win_col_hi = 4095, win_row_lo = 0, win_row_hi = 4095;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	changed_cell_run_coalescer_core #(.RUN_MAX(RUN_MAX)) dut (
		clk, arst_n, cfg_write, cfg_index, cfg_data,
		cell_valid, cell_ready, cell_word,
		run_valid, run_ready, run_word
	);

	ccrc_run_checker #(.RUN_MAX(RUN_MAX)) chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cell_valid(cell_valid), .cell_ready(cell_ready), .cell_word(cell_word),
		.run_valid(run_valid), .run_ready(run_ready), .run_word(run_word),
		.wrap_up(wrap_up), .mismatches(mismatches), .words_pending(words_pending)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Run-side ready: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				run_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else
				run_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one cell word and wait for it to be taken; returns on a falling edge
	task automatic send_cell(input cell_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cell_valid = 1'b0;
			@(negedge clk);
		end
		cell_word  = c;
		cell_valid = 1'b1;
		do @(posedge clk); while (!cell_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_fields(input int col, input int row, input int ncol, input int nglyph,
		input int ocol, input int oglyph, input bit last);
		cell_t c;
		c.column    = 12'(col);
		c.row       = 12'(row);
		c.new_color = 8'(ncol);
		c.new_glyph = 21'(nglyph);
		c.old_color = 8'(ocol);
		c.old_glyph = 21'(oglyph);
		c.span_end  = last;
		send_cell(c);
	endtask

	// Drop valid, wait out all expected words, then let the core settle
	task automatic wait_idle();
		cell_valid = 1'b0;
		do @(negedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_index = idx;
		cfg_data  = 13'(val);
		cfg_write = 1'b1;
		@(negedge clk);
	endtask

	// Write the whole register set while idle
	task automatic set_view(input int en, input int sc, input int sr, input int ec,
		input int er, input int oc, input int gw, input int gh);
		wait_idle();
		write_reg(CFG_VIEW_ENABLE, en);
		write_reg(CFG_VIEW_START_COL, sc);
		write_reg(CFG_VIEW_START_ROW, sr);
		write_reg(CFG_VIEW_END_COL, ec);
		write_reg(CFG_VIEW_END_ROW, er);
		write_reg(CFG_OLD_COMPARE, oc);
		write_reg(CFG_GLYPH_WIDTH, gw);
		write_reg(CFG_GLYPH_HEIGHT, gh);
		cfg_write = 1'b0;
		if (en != 0) begin
			win_col_lo = sc;
			win_col_hi = ec - 1;
			win_row_lo = sr;
			win_row_hi = er - 1;
		end else begin
			win_col_lo = 0;
			win_col_hi = 4095;
			win_row_lo = 0;
			win_row_hi = 4095;
		end
	endtask

	// Mostly in and just around the window, sometimes anywhere
	function automatic int near(input int lo, input int hi);
		int a, b;
		if (lo > hi) begin
			a  = hi;
			hi = lo;
			lo = a;
		end
		a = (lo < 3) ? 0 : lo - 3;
		b = (hi > 4093) ? 4095 : hi + 2;
		if ($urandom_range(99) < 20)
			return $urandom_range(4095);
		return $urandom_range(b, a);
	endfunction

	function automatic int rand_glyph();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return 0;
		if (pick == 1)
			return GLYPH_TOP;
		return $urandom_range(GLYPH_TOP);
	endfunction

	// One span: mostly consecutive columns on one row, colors from a two-color palette
	task automatic send_span(input int len, input bit mono, input bit broken);
		cell_t      c;
		logic [7:0] hue_a, hue_b;
		int         col, row, pick;
		row         = near(win_row_lo, win_row_hi);
		col         = near(win_col_lo, win_col_hi);
		hue_a       = 8'($urandom);
		hue_b       = 8'($urandom);
		c.new_color = hue_a;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0)
				col = $urandom_range(4095);
			c.column = 12'(col);
			c.row    = 12'(row);
			if (!mono && $urandom_range(99) < 15)
				c.new_color = (c.new_color == hue_a) ? hue_b : hue_a;
			c.new_glyph = 21'(rand_glyph());
			c.old_color = c.new_color;
			c.old_glyph = c.new_glyph;
			pick = $urandom_range(99);
			// a quarter of the cells stay equal to the old frame
			if (pick >= 25) begin
				case (pick % 3)
					0: c.old_color = c.new_color ^ 8'($urandom_range(255, 1));
					1: c.old_glyph = 21'(rand_glyph());
					default: begin
						c.old_color = 8'($urandom);
						c.old_glyph = 21'(rand_glyph());
					end
				endcase
			end
			c.span_end = (i == len - 1) && !broken;
			send_cell(c);
			col++;
		end
	endtask

	task automatic run_phase(input int quota);
		int start, len, pick;
		start = items_sent;
		while (items_sent - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 70)
				len = $urandom_range(8, 1);
			else if (pick < 90)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(70, 33);
			send_span(len, $urandom_range(4) == 0, $urandom_range(9) == 0);
		end
		// close any run a broken span left open
		send_span(1, 1'b0, 1'b0);
	endtask

	task automatic apply_setting(input int k);
		int sc, sr;
		case (k)
			0: set_view(1, 10, 5, 60, 40, 1, 64, 64);
			1: set_view(0, 4095, 4095, 0, 0, 0, 1, 1);
			2: set_view(1, 0, 0, 4096, 4096, 1, 7, 13);
			3: set_view(1, 200, 30, 100, 20, 0, 8, 16);
			4: set_view(0, $urandom_range(4095), $urandom_range(4095), $urandom_range(4096),
				$urandom_range(4096), 1, $urandom_range(64, 1), $urandom_range(64, 1));
			5: set_view(1, 4064, 4095, 4096, 4096, 1, 64, 1);
			default: begin
				sc = $urandom_range(4095);
				sr = $urandom_range(4095);
				set_view(1, sc, sr, sc + $urandom_range(80), sr + $urandom_range(3),
					$urandom_range(1), $urandom_range(64, 1), $urandom_range(64, 1));
			end
		endcase
		case (k % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: field extremes and a color change inside a span
		send_fields(0, 0, 0, 0, 0, 0, 1);
		send_fields(4095, 4095, 255, GLYPH_TOP, 255, GLYPH_TOP, 1);
		send_fields(10, 7, 3, 'h61, 0, 0, 0);
		send_fields(11, 7, 3, 'h62, 0, 0, 0);
		send_fields(12, 7, 4, 'h63, 0, 0, 1);

		// Window off with a non-zero origin: offsets wrap; old-frame compare on
		set_view(0, 5, 3, 4096, 4096, 1, 8, 16);
		send_fields(0, 0, 1, 'h41, 2, 'h41, 0);
		send_fields(1, 0, 1, 'h42, 1, 'h42, 0);
		send_fields(2, 0, 1, 'h43, 1, 'h44, 0);
		send_fields(3, 0, 1, 'h45, 2, 'h45, 0);
		send_fields(9, 0, 1, 'h46, 0, 0, 1);

		// Small window: edges in and out
		set_view(1, 5, 3, 8, 6, 0, 3, 5);
		send_fields(4, 3, 9, 'h71, 0, 0, 0);
		send_fields(5, 3, 9, 'h72, 0, 0, 0);
		send_fields(7, 3, 9, 'h73, 0, 0, 0);
		send_fields(8, 3, 9, 'h74, 0, 0, 0);
		send_fields(6, 6, 9, 'h75, 0, 0, 1);

		// Empty window
		set_view(1, 5, 3, 5, 6, 0, 3, 5);
		send_fields(5, 3, 9, 'h76, 0, 0, 1);

		// Random phases over register settings and idling patterns
		for (int k = 0; k < 7; k++) begin
			apply_setting(k);
			if (k == 2) begin
				hold_req = 1'b1;
				send_span(64, 1'b1, 1'b0);
			end
			run_phase((k == 3) ? 26 : 32);
		end

		wait_idle();
		wrap_up = 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
